@@ hdl/mexp_pkg.sv @@
`default_nettype none

package mexp_pkg;

   // Width of one field on the streaming ports.
   localparam int FIELD_WIDTH = 32;

   // Datapath width; inputs are cut to this many low bits.
   localparam int OPERAND_WIDTH = 32;

   // Width of a counter that walks over the datapath bits.
   localparam int COUNT_WIDTH = $clog2(OPERAND_WIDTH);

   // One request to the shared modular adder: (x + y + cin) mod m,
   // valid when x + y + cin < 2m.
   typedef struct packed {
      logic [OPERAND_WIDTH-1:0] x;
      logic [OPERAND_WIDTH-1:0] y;
      logic                     cin;
      logic [OPERAND_WIDTH-1:0] m;
   } add_req_type;

endpackage

`default_nettype wire

@@ hdl/mexp_modadd.sv @@
`default_nettype none

module mexp_modadd (
   input  mexp_pkg::add_req_type                  add_req,
   output logic [mexp_pkg::OPERAND_WIDTH-1:0]     add_sum
);
   import mexp_pkg::*;

   localparam int W = OPERAND_WIDTH;

   logic [W:0]   total;
   logic [W+1:0] diff;

   // Full sum and the sum less the modulus side by side; a negative
   // difference means the sum is already reduced.
   always_comb begin
      total = {1'b0, add_req.x} + {1'b0, add_req.y} + {{W{1'b0}}, add_req.cin};
      diff  = {1'b0, total} - {2'b00, add_req.m};
      if (diff[W+1]) begin
         add_sum = total[W-1:0];
      end else begin
         add_sum = diff[W-1:0];
      end
   end

endmodule

`default_nettype wire

@@ hdl/modular_exponentiation_core.sv @@
// Modular exponentiation core: power_result = base ^ exponent mod modulus.
//
// Request channel (req_): one word carries base, exponent and modulus. The
// core takes a word only while it is idle; req_tready drops for the whole
// computation. Response channel (rsp_): one word per request with the
// result in rsp_tdata and the zero-modulus error flag in rsp_tuser.
//
// All arithmetic runs through one modular adder under a sequencer. The
// base is first reduced by restoring division, one bit per cycle. Each
// exponent bit then takes a step in S_EXP plus up to two add-and-double
// multiplications, each with an accumulate step for a set multiplier bit,
// a doubling step per multiplier bit and a final step. A zero modulus
// goes from idle straight to the output state with a zero result.
//
// The finished result sits in an output register, so a new request is
// taken while an earlier response still waits for rsp_tready. A stalled
// receiver holds rsp_tdata and rsp_tuser steady; the core then waits with
// the next result until the register is free. Synchronous reset returns
// the sequencer to idle and drops rsp_tvalid.
`default_nettype none

module modular_exponentiation_core (
   input  wire                                      clock,
   input  wire                                      reset,
   // base_value [31:0], exponent_value [63:32], modulus_value [95:64]
   input  wire  [3*mexp_pkg::FIELD_WIDTH-1:0]       req_tdata,
   input  wire                                      req_tvalid,
   output logic                                     req_tready,
   // power_result [31:0]
   output logic [mexp_pkg::FIELD_WIDTH-1:0]         rsp_tdata,
   // modulus_error [0]
   output logic [0:0]                               rsp_tuser,
   output logic                                     rsp_tvalid,
   input  wire                                      rsp_tready
);
   import mexp_pkg::*;

   localparam int W  = OPERAND_WIDTH;
   localparam int FW = FIELD_WIDTH;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_REDUCE = 3'd1;
   localparam logic [2:0] S_EXP    = 3'd2;
   localparam logic [2:0] S_MUL    = 3'd3;
   localparam logic [2:0] S_OUT    = 3'd4;

   // Which multiplication is running.
   localparam logic SEL_RESULT = 1'b0;
   localparam logic SEL_SQUARE = 1'b1;

   // Adder operand choice.
   localparam logic [1:0] OP_REDUCE = 2'd0;
   localparam logic [1:0] OP_ACCUM  = 2'd1;
   localparam logic [1:0] OP_DOUBLE = 2'd2;

   logic [2:0]             state_ff, state_in;
   logic [W-1:0]           base_ff, base_in;
   logic [W-1:0]           expo_ff, expo_in;
   logic [W-1:0]           mod_ff, mod_in;
   logic [W-1:0]           result_ff, result_in;
   logic [W-1:0]           acc_ff, acc_in;
   logic [W-1:0]           mula_ff, mula_in;
   logic [W-1:0]           mulb_ff, mulb_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   phase_ff, phase_in;
   logic                   sel_ff, sel_in;
   logic                   err_ff, err_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]          rsp_data_ff, rsp_data_in;
   logic                   rsp_err_ff, rsp_err_in;

   logic [1:0]             add_op;
   add_req_type            add_req;
   logic [W-1:0]           add_sum;
   logic [W-1:0]           req_base;
   logic [W-1:0]           req_expo;
   logic [W-1:0]           req_mod;

   // Input fields cut to the datapath width.
   assign req_base = W'(req_tdata[FW-1:0]);
   assign req_expo = W'(req_tdata[2*FW-1:FW]);
   assign req_mod  = W'(req_tdata[3*FW-1:2*FW]);

   // Operand selection for the shared adder.
   always_comb begin
      add_op = OP_REDUCE;
      if (state_ff == S_MUL) begin
         if (!phase_ff && mulb_ff[0]) begin
            add_op = OP_ACCUM;
         end else begin
            add_op = OP_DOUBLE;
         end
      end
   end

   always_comb begin
      add_req.m   = mod_ff;
      add_req.cin = 1'b0;
      case (add_op)
         OP_ACCUM: begin
            add_req.x = acc_ff;
            add_req.y = mula_ff;
         end
         OP_DOUBLE: begin
            add_req.x = mula_ff;
            add_req.y = mula_ff;
         end
         default: begin
            add_req.x   = acc_ff;
            add_req.y   = acc_ff;
            add_req.cin = base_ff[W-1];
         end
      endcase
   end

   mexp_modadd u_modadd (
      .add_req (add_req),
      .add_sum (add_sum)
   );

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      expo_in      = expo_ff;
      mod_in       = mod_ff;
      result_in    = result_ff;
      acc_in       = acc_ff;
      mula_in      = mula_ff;
      mulb_in      = mulb_ff;
      count_in     = count_ff;
      phase_in     = phase_ff;
      sel_in       = sel_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;

      // The receiver took the waiting word.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               base_in   = req_base;
               expo_in   = req_expo;
               mod_in    = req_mod;
               result_in = {{(W-1){1'b0}}, 1'b1};
               acc_in    = '0;
               count_in  = COUNT_WIDTH'(W - 1);
               if (req_mod == '0) begin
                  result_in = '0;
                  err_in    = 1'b1;
                  state_in  = S_OUT;
               end else begin
                  err_in    = 1'b0;
                  state_in  = S_REDUCE;
               end
            end
         end

         // Restoring division of the base, most significant bit first.
         S_REDUCE: begin
            acc_in   = add_sum;
            base_in  = {base_ff[W-2:0], 1'b0};
            count_in = count_ff - 1'b1;
            if (count_ff == '0) begin
               base_in  = add_sum;
               state_in = S_EXP;
            end
         end

         // Pick the next multiplication for the current exponent bit, or finish once no exponent bits are left.
         S_EXP: begin
            acc_in   = '0;
            phase_in = 1'b0;
            if (expo_ff == '0) begin
               state_in = S_OUT;
            end else if (expo_ff[0]) begin
               mula_in  = result_ff;
               mulb_in  = base_ff;
               sel_in   = SEL_RESULT;
               state_in = S_MUL;
            end else begin
               mula_in  = base_ff;
               mulb_in  = base_ff;
               sel_in   = SEL_SQUARE;
               state_in = S_MUL;
            end
         end

         // Add-and-double multiplication, multiplier bits low first.
         S_MUL: begin
            if (!phase_ff && mulb_ff == '0) begin
               acc_in   = '0;
               if (sel_ff == SEL_RESULT) begin
                  result_in = acc_ff;
                  if (expo_ff[W-1:1] == '0) begin
                     state_in = S_OUT;
                  end else begin
                     mula_in = base_ff;
                     mulb_in = base_ff;
                     sel_in  = SEL_SQUARE;
                  end
               end else begin
                  base_in  = acc_ff;
                  expo_in  = {1'b0, expo_ff[W-1:1]};
                  state_in = S_EXP;
               end
            end else if (!phase_ff && mulb_ff[0]) begin
               acc_in   = add_sum;
               phase_in = 1'b1;
            end else begin
               mula_in  = add_sum;
               mulb_in  = {1'b0, mulb_ff[W-1:1]};
               phase_in = 1'b0;
            end
         end

         // Hand the result over once the output register is free.
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = FW'(result_ff);
               rsp_err_in   = err_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff     <= base_in;
      expo_ff     <= expo_in;
      mod_ff      <= mod_in;
      result_ff   <= result_in;
      acc_ff      <= acc_in;
      mula_ff     <= mula_in;
      mulb_ff     <= mulb_in;
      count_ff    <= count_in;
      phase_ff    <= phase_in;
      sel_ff      <= sel_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign req_tready   = (state_ff == S_IDLE);
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_err_ff;

endmodule

`default_nettype wire

@@ hdl/mexp_checker.sv @@
`default_nettype none

module mexp_checker (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire  [3*mexp_pkg::FIELD_WIDTH-1:0]  req_tdata,
   input  wire                                 req_tvalid,
   input  wire                                 req_tready,
   input  wire  [mexp_pkg::FIELD_WIDTH-1:0]    rsp_tdata,
   input  wire  [0:0]                          rsp_tuser,
   input  wire                                 rsp_tvalid,
   input  wire                                 rsp_tready
);
   import mexp_pkg::*;

   // A waiting response word holds until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response word changed while stalled");

   // The error flag always comes with a zero result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("modulus error with nonzero result");

   // The core is busy right after it takes a request.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a computation was starting");

   // Reset leaves no response pending.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (.*);

`default_nettype wire
